[src/mctt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared types and constants for the MIDI clock tempo tracker.
// ----------------------------------------------------------------------------
package mctt_pkg;

    localparam int AVERAGE_WINDOW_DEF = 32;
    localparam int TICKS_PER_BEAT_DEF = 24;

    localparam int SR_W       = 18;
    localparam int BPM_W      = 17;
    localparam int PERIOD_W   = 19;
    localparam int OFFSET_W   = 16;
    localparam int POS_W      = 48;
    localparam int NUM_W      = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SR_W-1:0]     SR_MIN       = 18'd8000;
    localparam logic [SR_W-1:0]     SR_MAX       = 18'd192000;
    localparam logic [SR_W-1:0]     SR_RESET     = 18'd48000;
    localparam logic [BPM_W-1:0]    BPM_MIN      = 17'd7680;
    localparam logic [BPM_W-1:0]    BPM_MAX      = 17'd76800;
    localparam logic [BPM_W-1:0]    BPM_RESET    = 17'd30720;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 19'd24000;
    // 60 s/min * 256 (Q.8)
    localparam logic [NUM_W-1:0]    NUM_SCALE    = 32'd15360;
    localparam int                  MIN_INTERVALS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE  = 1'b0,
        REG_INTERNAL_BPM = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CFG_WRITE,
        OP_DIV_CFG,
        OP_CFG_FIN,
        OP_LOAD,
        OP_TICK,
        OP_SUM_START,
        OP_SUM_RUN,
        OP_DIV_AVG,
        OP_MUL,
        OP_DIV_EST,
        OP_CLAMP,
        OP_DIV_PER,
        OP_PER_FIN,
        OP_ADV,
        OP_DIV_WRAP,
        OP_WRAP_FIN,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CFG_DIV,
        ST_CFG_WAIT,
        ST_CFG_FIN,
        ST_TICK,
        ST_TICK_CHK,
        ST_SUM_START,
        ST_SUM_RUN,
        ST_AVG_DIV,
        ST_AVG_WAIT,
        ST_MUL,
        ST_EST_DIV,
        ST_EST_WAIT,
        ST_CLAMP,
        ST_PER_DIV,
        ST_PER_WAIT,
        ST_PER_FIN,
        ST_ADV,
        ST_ADV_CHK,
        ST_WRAP_DIV,
        ST_WRAP_WAIT,
        ST_WRAP_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic div_done;
        logic sum_done;
        logic est_go;
        logic wrap_go;
        logic out_free;
    } dp_status_t;

endpackage

[src/mctt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mctt_div #(
    parameter int DW = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mctt_pkg::NUM_W-1:0]  num,
    input  logic [DW-1:0]               den,
    output logic                        done,
    output logic [mctt_pkg::NUM_W-1:0]  quo,
    output logic [DW-1:0]               rem
);

    localparam int NW  = mctt_pkg::NUM_W;
    localparam int CW  = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        diff      = shifted - {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[src/mctt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_datapath
// Tracker state, interval ring, divider and result register.
// ----------------------------------------------------------------------------
module mctt_datapath #(
    parameter int AVERAGE_WINDOW = mctt_pkg::AVERAGE_WINDOW_DEF,
    parameter int TICKS_PER_BEAT = mctt_pkg::TICKS_PER_BEAT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mctt_pkg::dp_op_t                  op,
    input  logic [mctt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mctt_pkg::SR_W-1:0]         cfg_data,
    input  logic [mctt_pkg::OFFSET_W-1:0]     in_tick_offset,
    input  logic [mctt_pkg::OFFSET_W-1:0]     in_advance,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [mctt_pkg::BPM_W-1:0]        out_bpm,
    output logic [mctt_pkg::PERIOD_W-1:0]     out_to_beat,
    output logic                              out_locked,
    output mctt_pkg::dp_status_t              status
);

    localparam int IDX_W = $clog2(AVERAGE_WINDOW);
    localparam int CNT_W = $clog2(AVERAGE_WINDOW + 1);
    localparam int PW    = mctt_pkg::PERIOD_W;
    localparam int BW    = mctt_pkg::BPM_W;
    localparam int SW    = mctt_pkg::SR_W;
    localparam int OW    = mctt_pkg::OFFSET_W;
    localparam int XW    = mctt_pkg::POS_W;
    localparam int NW    = mctt_pkg::NUM_W;
    localparam int DEN_W = PW + $clog2(TICKS_PER_BEAT + 1);
    localparam int SUM_W = PW + CNT_W;

    logic [SW-1:0]    sr_reg, sr_next;
    logic [BW-1:0]    ib_reg, ib_next;
    logic [PW-1:0]    ib_per_reg, ib_per_next;
    logic [XW-1:0]    pos_reg, pos_next;
    logic [XW-1:0]    last_reg, last_next;
    logic             seen_reg, seen_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [BW-1:0]    est_reg, est_next;
    logic [PW-1:0]    bp_reg, bp_next;
    logic [PW-1:0]    cd_reg, cd_next;
    logic             cfg_sr_reg, cfg_sr_next;
    logic             est_go_reg, est_go_next;
    logic             wrap_go_reg, wrap_go_next;
    logic [OW-1:0]    m_reg, m_next;
    logic [OW-1:0]    off_reg, off_next;
    logic [OW-1:0]    adv_reg, adv_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             out_valid_reg, out_valid_next;
    logic [BW-1:0]    out_bpm_reg, out_bpm_next;
    logic [PW-1:0]    out_tb_reg, out_tb_next;
    logic             out_lk_reg, out_lk_next;

    logic [PW-1:0]    ring [AVERAGE_WINDOW];
    logic [PW-1:0]    rd_data_reg;
    logic             ring_we;
    logic             ring_re;

    logic [XW-1:0]    tick_pos;
    logic [XW-1:0]    tick_diff;
    logic [XW-1:0]    lag;
    logic             locked;
    logic [NW-1:0]    scaled;
    logic             div_start;
    logic [NW-1:0]    div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NW-1:0]    div_q;
    logic [DEN_W-1:0] div_r;
    logic [DEN_W-1:0] prod;

    mctt_div #(
        .DW (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q),
        .rem   (div_r)
    );

    // lock: tick ahead of the position, or less than half a second behind
    always_comb
    begin
        lag    = pos_reg - last_reg;
        locked = seen_reg && ((last_reg > pos_reg) ||
                              ({lag, 1'b0} < (XW + 1)'(sr_reg)));
        scaled = NW'(sr_reg) * mctt_pkg::NUM_SCALE;
    end

    always_comb
    begin
        div_start = 1'b1;
        div_num   = scaled;
        div_den   = '0;
        case (op)
            mctt_pkg::OP_DIV_CFG:  div_den = DEN_W'(ib_reg);
            mctt_pkg::OP_DIV_AVG:
            begin
                div_num = NW'(sum_reg);
                div_den = DEN_W'(cnt_reg);
            end
            mctt_pkg::OP_DIV_EST:  div_den = den_reg;
            mctt_pkg::OP_DIV_PER:  div_den = DEN_W'(est_reg);
            mctt_pkg::OP_DIV_WRAP:
            begin
                div_num = NW'(m_reg);
                div_den = DEN_W'(bp_reg);
            end
            default:               div_start = 1'b0;
        endcase
    end

    always_comb
    begin
        sr_next        = sr_reg;
        ib_next        = ib_reg;
        ib_per_next    = ib_per_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        seen_next      = seen_reg;
        widx_next      = widx_reg;
        cnt_next       = cnt_reg;
        est_next       = est_reg;
        bp_next        = bp_reg;
        cd_next        = cd_reg;
        cfg_sr_next    = cfg_sr_reg;
        est_go_next    = est_go_reg;
        wrap_go_next   = wrap_go_reg;
        m_next         = m_reg;
        off_next       = off_reg;
        adv_next       = adv_reg;
        sum_next       = sum_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        den_next       = den_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_bpm_next   = out_bpm_reg;
        out_tb_next    = out_tb_reg;
        out_lk_next    = out_lk_reg;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        tick_pos       = pos_reg + XW'(off_reg);
        tick_diff      = tick_pos - last_reg;
        prod           = DEN_W'(div_q[PW-1:0]) * DEN_W'(TICKS_PER_BEAT);

        case (op)
            mctt_pkg::OP_CFG_WRITE:
            begin
                if (cfg_index == mctt_pkg::REG_SAMPLE_RATE)
                begin
                    if (cfg_data < mctt_pkg::SR_MIN)
                        sr_next = mctt_pkg::SR_MIN;
                    else if (cfg_data > mctt_pkg::SR_MAX)
                        sr_next = mctt_pkg::SR_MAX;
                    else
                        sr_next = cfg_data;
                    pos_next    = '0;
                    last_next   = '0;
                    seen_next   = 1'b0;
                    widx_next   = '0;
                    cnt_next    = '0;
                    cfg_sr_next = 1'b1;
                end
                else
                begin
                    if (cfg_data[BW-1:0] < mctt_pkg::BPM_MIN)
                        ib_next = mctt_pkg::BPM_MIN;
                    else if (cfg_data[BW-1:0] > mctt_pkg::BPM_MAX)
                        ib_next = mctt_pkg::BPM_MAX;
                    else
                        ib_next = cfg_data[BW-1:0];
                    cfg_sr_next = 1'b0;
                end
            end
            mctt_pkg::OP_CFG_FIN:
            begin
                ib_per_next = div_q[PW-1:0];
                if (cfg_sr_reg)
                begin
                    bp_next = div_q[PW-1:0];
                    cd_next = div_q[PW-1:0];
                end
                else if (!locked)
                    bp_next = div_q[PW-1:0];
            end
            mctt_pkg::OP_LOAD:
            begin
                off_next = in_tick_offset;
                adv_next = in_advance;
            end
            mctt_pkg::OP_TICK:
            begin
                if (seen_reg && (tick_pos > last_reg) &&
                    (tick_diff < XW'({sr_reg, 1'b0})))
                begin
                    ring_we = 1'b1;
                    if (widx_reg == IDX_W'(AVERAGE_WINDOW - 1))
                        widx_next = '0;
                    else
                        widx_next = widx_reg + 1'b1;
                    if (cnt_reg < CNT_W'(AVERAGE_WINDOW))
                        cnt_next = cnt_reg + 1'b1;
                end
                est_go_next = seen_reg &&
                              (cnt_next >= CNT_W'(mctt_pkg::MIN_INTERVALS));
                last_next   = tick_pos;
                seen_next   = 1'b1;
            end
            mctt_pkg::OP_SUM_START:
            begin
                sum_next   = '0;
                issue_next = '0;
            end
            mctt_pkg::OP_SUM_RUN:
            begin
                if (issue_reg < cnt_reg)
                begin
                    ring_re     = 1'b1;
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
                if (rd_vld_reg)
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
            end
            mctt_pkg::OP_MUL:
                den_next = (prod == '0) ? DEN_W'(1) : prod;
            mctt_pkg::OP_CLAMP:
            begin
                if (div_q < NW'(mctt_pkg::BPM_MIN))
                    est_next = mctt_pkg::BPM_MIN;
                else if (div_q > NW'(mctt_pkg::BPM_MAX))
                    est_next = mctt_pkg::BPM_MAX;
                else
                    est_next = div_q[BW-1:0];
            end
            mctt_pkg::OP_PER_FIN:
                bp_next = div_q[PW-1:0];
            mctt_pkg::OP_ADV:
            begin
                if (!locked)
                    bp_next = ib_per_reg;
                if (cd_reg > PW'(adv_reg))
                begin
                    cd_next      = cd_reg - PW'(adv_reg);
                    wrap_go_next = 1'b0;
                end
                else
                begin
                    // overshoot is below one block, so cd fits in the offset width
                    m_next       = adv_reg - cd_reg[OW-1:0];
                    wrap_go_next = 1'b1;
                end
                pos_next = pos_reg + XW'(adv_reg);
            end
            mctt_pkg::OP_WRAP_FIN:
                cd_next = bp_reg - div_r[PW-1:0];
            mctt_pkg::OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_bpm_next   = locked ? est_reg : ib_reg;
                out_tb_next    = cd_reg;
                out_lk_next    = locked;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg        <= mctt_pkg::SR_RESET;
            ib_reg        <= mctt_pkg::BPM_RESET;
            ib_per_reg    <= mctt_pkg::PERIOD_RESET;
            pos_reg       <= '0;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            widx_reg      <= '0;
            cnt_reg       <= '0;
            est_reg       <= mctt_pkg::BPM_RESET;
            bp_reg        <= mctt_pkg::PERIOD_RESET;
            cd_reg        <= mctt_pkg::PERIOD_RESET;
            cfg_sr_reg    <= 1'b0;
            est_go_reg    <= 1'b0;
            wrap_go_reg   <= 1'b0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sr_reg        <= sr_next;
            ib_reg        <= ib_next;
            ib_per_reg    <= ib_per_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            seen_reg      <= seen_next;
            widx_reg      <= widx_next;
            cnt_reg       <= cnt_next;
            est_reg       <= est_next;
            bp_reg        <= bp_next;
            cd_reg        <= cd_next;
            cfg_sr_reg    <= cfg_sr_next;
            est_go_reg    <= est_go_next;
            wrap_go_reg   <= wrap_go_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        off_reg     <= off_next;
        adv_reg     <= adv_next;
        sum_reg     <= sum_next;
        den_reg     <= den_next;
        out_bpm_reg <= out_bpm_next;
        out_tb_reg  <= out_tb_next;
        out_lk_reg  <= out_lk_next;
    end

    // interval ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[widx_reg] <= tick_diff[PW-1:0];
        if (ring_re)
            rd_data_reg <= ring[issue_reg[IDX_W-1:0]];
    end

    assign out_valid   = out_valid_reg;
    assign out_bpm     = out_bpm_reg;
    assign out_to_beat = out_tb_reg;
    assign out_locked  = out_lk_reg;

    assign status.div_done = div_done;
    assign status.sum_done = (issue_reg == cnt_reg) && !rd_vld_reg;
    assign status.est_go   = est_go_reg;
    assign status.wrap_go  = wrap_go_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

[src/mctt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_ctrl
// Sequencer: walks each beat and config write through the datapath.
// ----------------------------------------------------------------------------
module mctt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  in_valid,
    input  logic                  in_is_adv,
    input  mctt_pkg::dp_status_t  status,
    output logic                  cfg_ready,
    output logic                  in_ready,
    output mctt_pkg::dp_op_t      op
);

    mctt_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mctt_pkg::ST_IDLE:
            begin
                if (cfg_valid)
                    state_next = mctt_pkg::ST_CFG_DIV;
                else if (in_valid)
                    state_next = in_is_adv ? mctt_pkg::ST_ADV : mctt_pkg::ST_TICK;
            end
            mctt_pkg::ST_CFG_DIV:  state_next = mctt_pkg::ST_CFG_WAIT;
            mctt_pkg::ST_CFG_WAIT:
                if (status.div_done)
                    state_next = mctt_pkg::ST_CFG_FIN;
            mctt_pkg::ST_CFG_FIN:  state_next = mctt_pkg::ST_IDLE;
            mctt_pkg::ST_TICK:     state_next = mctt_pkg::ST_TICK_CHK;
            mctt_pkg::ST_TICK_CHK:
                state_next = status.est_go ? mctt_pkg::ST_SUM_START : mctt_pkg::ST_OUT;
            mctt_pkg::ST_SUM_START: state_next = mctt_pkg::ST_SUM_RUN;
            mctt_pkg::ST_SUM_RUN:
                if (status.sum_done)
                    state_next = mctt_pkg::ST_AVG_DIV;
            mctt_pkg::ST_AVG_DIV:  state_next = mctt_pkg::ST_AVG_WAIT;
            mctt_pkg::ST_AVG_WAIT:
                if (status.div_done)
                    state_next = mctt_pkg::ST_MUL;
            mctt_pkg::ST_MUL:      state_next = mctt_pkg::ST_EST_DIV;
            mctt_pkg::ST_EST_DIV:  state_next = mctt_pkg::ST_EST_WAIT;
            mctt_pkg::ST_EST_WAIT:
                if (status.div_done)
                    state_next = mctt_pkg::ST_CLAMP;
            mctt_pkg::ST_CLAMP:    state_next = mctt_pkg::ST_PER_DIV;
            mctt_pkg::ST_PER_DIV:  state_next = mctt_pkg::ST_PER_WAIT;
            mctt_pkg::ST_PER_WAIT:
                if (status.div_done)
                    state_next = mctt_pkg::ST_PER_FIN;
            mctt_pkg::ST_PER_FIN:  state_next = mctt_pkg::ST_OUT;
            mctt_pkg::ST_ADV:      state_next = mctt_pkg::ST_ADV_CHK;
            mctt_pkg::ST_ADV_CHK:
                state_next = status.wrap_go ? mctt_pkg::ST_WRAP_DIV : mctt_pkg::ST_OUT;
            mctt_pkg::ST_WRAP_DIV: state_next = mctt_pkg::ST_WRAP_WAIT;
            mctt_pkg::ST_WRAP_WAIT:
                if (status.div_done)
                    state_next = mctt_pkg::ST_WRAP_FIN;
            mctt_pkg::ST_WRAP_FIN: state_next = mctt_pkg::ST_OUT;
            mctt_pkg::ST_OUT:
                if (status.out_free)
                    state_next = mctt_pkg::ST_IDLE;
            default:               state_next = mctt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op        = mctt_pkg::OP_NONE;
        cfg_ready = 1'b0;
        in_ready  = 1'b0;
        case (state_reg)
            mctt_pkg::ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                    op = mctt_pkg::OP_CFG_WRITE;
                else if (in_valid)
                    op = mctt_pkg::OP_LOAD;
            end
            mctt_pkg::ST_CFG_DIV:   op = mctt_pkg::OP_DIV_CFG;
            mctt_pkg::ST_CFG_FIN:   op = mctt_pkg::OP_CFG_FIN;
            mctt_pkg::ST_TICK:      op = mctt_pkg::OP_TICK;
            mctt_pkg::ST_SUM_START: op = mctt_pkg::OP_SUM_START;
            mctt_pkg::ST_SUM_RUN:   op = mctt_pkg::OP_SUM_RUN;
            mctt_pkg::ST_AVG_DIV:   op = mctt_pkg::OP_DIV_AVG;
            mctt_pkg::ST_MUL:       op = mctt_pkg::OP_MUL;
            mctt_pkg::ST_EST_DIV:   op = mctt_pkg::OP_DIV_EST;
            mctt_pkg::ST_CLAMP:     op = mctt_pkg::OP_CLAMP;
            mctt_pkg::ST_PER_DIV:   op = mctt_pkg::OP_DIV_PER;
            mctt_pkg::ST_PER_FIN:   op = mctt_pkg::OP_PER_FIN;
            mctt_pkg::ST_ADV:       op = mctt_pkg::OP_ADV;
            mctt_pkg::ST_WRAP_DIV:  op = mctt_pkg::OP_DIV_WRAP;
            mctt_pkg::ST_WRAP_FIN:  op = mctt_pkg::OP_WRAP_FIN;
            mctt_pkg::ST_OUT:
                if (status.out_free)
                    op = mctt_pkg::OP_OUT;
            default:                op = mctt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mctt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[src/midi_clock_tempo_tracker.sv]
`timescale 1ns / 1ps
// Work per beat: an advance beat adds one remainder division when the beat
//   phase wraps; a tick beat, once the estimate runs, sums the N held
//   intervals in the ring and then runs three 32-step divisions.
// Throughput: one beat at a time; the shared 1-bit/cycle divider, the ring sum and result back-pressure set it.
// Config write: one period division. Reset: async, active low;
//   120 BPM, 48 kHz, period and countdown 24000, ring contents undefined.
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker
// Tempo estimate from incoming MIDI clock messages with a beat phase countdown.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker #(
    parameter int AVERAGE_WINDOW = mctt_pkg::AVERAGE_WINDOW_DEF,
    parameter int TICKS_PER_BEAT = mctt_pkg::TICKS_PER_BEAT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // tick_offset, advance_samples
    input  logic                           s_tuser,   // req_type (1 = advance)
    // result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // current_bpm, samples_to_beat, pad
    output logic                           m_tuser,   // clock_locked
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mctt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mctt_pkg::SR_W-1:0]      cfg_data
);

    mctt_pkg::dp_op_t              op;
    mctt_pkg::dp_status_t          status;
    logic [mctt_pkg::BPM_W-1:0]    out_bpm;
    logic [mctt_pkg::PERIOD_W-1:0] out_to_beat;
    logic                          out_locked;

    // The controller owns all sequencing: a beat enters only in idle, then
    // tick or advance processing runs to completion and parks in the output
    // state until the result register is free. The result register lets the
    // next beat be accepted while the previous result is still waiting.
    mctt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .in_valid  (s_tvalid),
        .in_is_adv (s_tuser),
        .status    (status),
        .cfg_ready (cfg_ready),
        .in_ready  (s_tready),
        .op        (op)
    );

    // The datapath holds tracker state, the interval ring (one write, one
    // registered read) and one divider shared by the average, the BPM
    // estimate, the beat periods and the phase wrap.
    mctt_datapath #(
        .AVERAGE_WINDOW (AVERAGE_WINDOW),
        .TICKS_PER_BEAT (TICKS_PER_BEAT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_tick_offset (s_tdata[15:0]),
        .in_advance     (s_tdata[31:16]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_bpm        (out_bpm),
        .out_to_beat    (out_to_beat),
        .out_locked     (out_locked),
        .status         (status)
    );

    assign m_tdata = {4'b0, out_to_beat, out_bpm};
    assign m_tuser = out_locked;

    // A register write and an input beat never land on the same edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && s_tvalid && s_tready))
        else $error("config write and input beat accepted together");

    // Beat countdown is always at least one sample when reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:17] != '0))
        else $error("samples_to_beat reported as zero");

    // Reported tempo stays inside the clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[16:0] >= mctt_pkg::BPM_MIN) &&
                      (m_tdata[16:0] <= mctt_pkg::BPM_MAX)))
        else $error("current_bpm out of range");

    // Nothing is accepted while a result is being produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready && !cfg_ready)
        else $error("accepted work while busy");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for midi_clock_tempo_tracker. Tick and advance beats go
// in with random gaps while the result side stalls at random. A tempo tracker
// model, kept in step at every accepted beat and register write, predicts each
// result beat. Runs cover register extremes, steady clock streams at random
// tempos, future and rejected ticks, and random noise.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WINDOW       = mctt_pkg::AVERAGE_WINDOW_DEF;
    localparam int TPB          = mctt_pkg::TICKS_PER_BEAT_DEF;
    localparam int IDLE_SETTLE  = 250;     // longest tick estimate plus margin
    localparam int STALL_LIMIT  = 20000;   // cycles with no handshake at all
    localparam logic [47:0] POS_MASK = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [16:0] bpm;
        logic [18:0] to_beat;
        logic        locked;
    } tempo_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // [15:0] tick_offset, [31:16] advance_samples
    logic        s_tuser;      // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;      // [16:0] current_bpm, [35:17] samples_to_beat
    logic        m_tuser;      // clock_locked
    logic        cfg_valid;
    logic        cfg_ready;
    logic [mctt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mctt_pkg::SR_W-1:0]      cfg_data;

    midi_clock_tempo_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Tracker model state
    // ------------------------------------------------------------------------
    logic [17:0] m_rate;
    logic [16:0] m_int_bpm;
    logic [16:0] m_est_bpm;
    logic [47:0] m_pos;
    logic [47:0] m_last_tick;
    logic        m_tick_seen;
    logic [18:0] m_ring [WINDOW];
    int          m_widx;
    int          m_count;
    logic [18:0] m_period;
    longint      m_countdown;

    tempo_res_t  pending_results[$];
    int          errors;
    int          beats_sent;
    int          results_seen;
    int          ticks_sent;
    int          locked_seen;
    int          cfg_writes;
    int          hold_cycles;     // long receiver hold-off request
    int          idle_count;
    bit          gapless;         // sender offers back to back

    function automatic logic [18:0] period_for(logic [16:0] bpm);
        return 19'((64'(m_rate) * 15360) / bpm);
    endfunction

    function automatic bit clock_is_locked();
        if (!m_tick_seen)
            return 1'b0;
        if (m_last_tick > m_pos)
            return 1'b1;
        return (64'(m_pos - m_last_tick) * 2) < 64'(m_rate);
    endfunction

    task automatic model_prepare();
        m_pos = '0;
        m_last_tick = '0;
        m_tick_seen = 1'b0;
        m_widx = 0;
        m_count = 0;
        m_period = period_for(m_int_bpm);
        m_countdown = longint'(m_period);
    endtask

    task automatic model_reset();
        m_rate = 18'd48000;
        m_int_bpm = 17'd30720;
        m_est_bpm = 17'd30720;
        model_prepare();
    endtask

    task automatic model_config(mctt_pkg::reg_idx_t idx, logic [17:0] value);
        logic [17:0] v;
        if (idx == mctt_pkg::REG_SAMPLE_RATE)
        begin
            v = value;
            if (v < mctt_pkg::SR_MIN) v = mctt_pkg::SR_MIN;
            if (v > mctt_pkg::SR_MAX) v = mctt_pkg::SR_MAX;
            m_rate = v;
            model_prepare();
        end
        else
        begin
            v = {1'b0, value[16:0]};
            if (v < 18'(mctt_pkg::BPM_MIN)) v = 18'(mctt_pkg::BPM_MIN);
            if (v > 18'(mctt_pkg::BPM_MAX)) v = 18'(mctt_pkg::BPM_MAX);
            m_int_bpm = v[16:0];
            if (!clock_is_locked())
                m_period = period_for(m_int_bpm);
        end
    endtask

    // one beat through the tracker model; result appended to the queue
    task automatic tempo_predict(bit is_adv, logic [15:0] offset, logic [15:0] nsamp);
        logic [47:0] tick_pos;
        longint      sum, avg, den, q, k;
        tempo_res_t  r;
        bit          lk;
        if (!is_adv)
        begin
            tick_pos = (m_pos + 48'(offset)) & POS_MASK;
            if (m_tick_seen)
            begin
                if (tick_pos > m_last_tick &&
                    64'(tick_pos - m_last_tick) < 64'(m_rate) * 2)
                begin
                    m_ring[m_widx] = 19'(tick_pos - m_last_tick);
                    m_widx = (m_widx + 1) % WINDOW;
                    if (m_count < WINDOW)
                        m_count++;
                end
                if (m_count >= mctt_pkg::MIN_INTERVALS)
                begin
                    sum = 0;
                    for (int i = 0; i < m_count; i++)
                        sum += m_ring[i];
                    avg = sum / m_count;
                    den = avg * TPB;
                    if (den == 0) den = 1;
                    q = (longint'(m_rate) * 15360) / den;
                    if (q < mctt_pkg::BPM_MIN) q = mctt_pkg::BPM_MIN;
                    if (q > mctt_pkg::BPM_MAX) q = mctt_pkg::BPM_MAX;
                    m_est_bpm = 17'(q);
                    m_period = period_for(m_est_bpm);
                end
            end
            m_last_tick = tick_pos;
            m_tick_seen = 1'b1;
        end
        else
        begin
            if (!clock_is_locked())
                m_period = period_for(m_int_bpm);
            m_countdown -= longint'(nsamp);
            if (m_countdown <= 0 && m_period > 0)
            begin
                k = (-m_countdown) / longint'(m_period) + 1;
                m_countdown += k * longint'(m_period);
            end
            m_pos = (m_pos + 48'(nsamp)) & POS_MASK;
        end
        lk = clock_is_locked();
        r.bpm = lk ? m_est_bpm : m_int_bpm;
        r.to_beat = m_countdown < 0 ? 19'd0 : 19'(m_countdown);
        r.locked = lk;
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int p;
        if (gapless)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 20);
        return $urandom_range(21, 120);
    endfunction

    task automatic send_beat(bit is_adv, logic [15:0] offset, logic [15:0] nsamp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_adv;
        s_tdata  <= {nsamp, offset};
        do @(posedge clk); while (!s_tready);
        tempo_predict(is_adv, offset, nsamp);
        beats_sent++;
        if (!is_adv) ticks_sent++;
    endtask

    task automatic send_tick(logic [15:0] offset);
        send_beat(1'b0, offset, 16'($urandom));
    endtask

    task automatic send_advance(logic [15:0] nsamp);
        send_beat(1'b1, 16'($urandom), nsamp);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // registers change only with the tracker idle, including dropped work
    task automatic write_reg(mctt_pkg::reg_idx_t idx, logic [17:0] value);
        wait_all_results();
        repeat (IDLE_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        model_config(idx, value);
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // steady clock stream: ticks every interval with a little jitter,
    // interleaved with audio blocks of random size
    task automatic clock_stream(int bpm_q8, int nbeats);
        int interval, next_tick, blk, jit, sent;
        interval = int'((longint'(m_rate) * 15360) / (longint'(bpm_q8) * TPB));
        if (interval < 2) interval = 2;
        next_tick = $urandom_range(0, interval);
        sent = 0;
        while (sent < nbeats)
        begin
            blk = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                            : $urandom_range(64, 2048);
            while (next_tick < blk && sent < nbeats)
            begin
                send_tick(16'(next_tick));
                sent++;
                jit = $urandom_range(0, 6) - 3;
                next_tick += (interval + jit > 1) ? interval + jit : 1;
            end
            if (sent < nbeats)
            begin
                send_advance(16'(blk));
                sent++;
                next_tick -= blk;
            end
        end
    endtask

    task automatic random_noise(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: send_tick(16'($urandom));
                1: send_tick(16'($urandom_range(0, 3000)));
                2: send_advance(16'($urandom));
                default: send_advance(16'($urandom_range(0, 4000)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_field_extremes();
        send_advance(16'd0);
        send_tick(16'd0);             // first tick: nothing stored
        send_tick(16'hFFFF);          // tick ahead of position: locked
        send_advance(16'hFFFF);
        send_tick(16'd0);             // at the last tick's position: rejected
        send_advance(16'd1);
        send_tick(16'hAAAA);
        send_tick(16'h5555);
        send_advance(16'h5555);
        send_advance(16'hAAAA);       // lock lost, internal tempo again
    endtask

    task automatic test_estimate_lock();
        // eleven ticks 1000 samples apart (120 BPM pace): estimate runs once 8 held
        for (int i = 0; i < 11; i++)
        begin
            send_tick(16'd100);
            send_advance(16'd1000);
        end
        send_tick(16'd60000);          // gap under two seconds: still stored
    endtask

    task automatic test_register_extremes();
        write_reg(mctt_pkg::REG_SAMPLE_RATE, 18'd8000);
        write_reg(mctt_pkg::REG_INTERNAL_BPM, 18'd7680);
        clock_stream(7680, 30);
        write_reg(mctt_pkg::REG_INTERNAL_BPM, 18'd76800);  // may be locked: kept period
        clock_stream(76800, 40);
        write_reg(mctt_pkg::REG_SAMPLE_RATE, 18'd192000);
        clock_stream(60 * 256, 40);
        write_reg(mctt_pkg::REG_SAMPLE_RATE, 18'd0);        // saturates low
        write_reg(mctt_pkg::REG_INTERNAL_BPM, 18'd0);
        random_noise(10);
        write_reg(mctt_pkg::REG_SAMPLE_RATE, 18'h3FFFF);    // saturates high
        write_reg(mctt_pkg::REG_INTERNAL_BPM, 18'h3FFFF);
        random_noise(10);
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        gapless = 1'b1;
        clock_stream(30720, 16);
        gapless = 1'b0;
        wait_all_results();           // sender pause until all results in
        clock_stream(30720, 16);
    endtask

    task automatic test_random_tempos();
        int rates[5] = '{44100, 48000, 96000, 22050, 176400};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(mctt_pkg::REG_SAMPLE_RATE, 18'(rates[ph]));
            write_reg(mctt_pkg::REG_INTERNAL_BPM, 18'($urandom_range(7680, 76800)));
            for (int s = 0; s < 4; s++)
            begin
                clock_stream($urandom_range(7000, 78000), $urandom_range(20, 35));
                random_noise($urandom_range(2, 6));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        tempo_res_t exp_r;
        tempo_res_t got;
        if (m_tvalid && m_tready)
        begin
            got.bpm = m_tdata[16:0];
            got.to_beat = m_tdata[35:17];
            got.locked = m_tuser;
            results_seen++;
            if (got.locked) locked_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result bpm=%0d to_beat=%0d locked=%0b",
                         $time, got.bpm, got.to_beat, got.locked);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.bpm !== exp_r.bpm)
                begin
                    errors++;
                    $display("%0t: current_bpm expected %0d actual %0d",
                             $time, exp_r.bpm, got.bpm);
                end
                if (got.to_beat !== exp_r.to_beat)
                begin
                    errors++;
                    $display("%0t: samples_to_beat expected %0d actual %0d",
                             $time, exp_r.to_beat, got.to_beat);
                end
                if (got.locked !== exp_r.locked)
                begin
                    errors++;
                    $display("%0t: clock_locked expected %0b actual %0b",
                             $time, exp_r.locked, got.locked);
                end
            end
        end
    end

    // ready pattern: mostly short stalls, some long, stretches of none
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        int p;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (hold_cycles > 0)
        begin
            stall_left = hold_cycles;
            hold_cycles = 0;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 60)      m_tready <= 1'b1;
            else if (p < 92) begin stall_left = $urandom_range(0, 3); m_tready <= 1'b0; end
            else if (p < 98) begin stall_left = $urandom_range(4, 30); m_tready <= 1'b0; end
            else             begin stall_left = $urandom_range(31, 150); m_tready <= 1'b0; end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mctt_pkg::REG_SAMPLE_RATE;
        cfg_data = '0;
        errors = 0;
        beats_sent = 0;
        results_seen = 0;
        ticks_sent = 0;
        locked_seen = 0;
        cfg_writes = 0;
        hold_cycles = 0;
        idle_count = 0;
        gapless = 1'b0;
        model_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_estimate_lock();
        test_register_extremes();
        test_backpressure();
        test_random_tempos();

        wait_all_results();
        repeat (IDLE_SETTLE) @(posedge clk);
        $display("Covered %0d beats (%0d ticks), %0d results, %0d locked, %0d reg writes",
                 beats_sent, ticks_sent, results_seen, locked_seen, cfg_writes);
        $display("Rate and tempo extremes, steady streams, future and rejected ticks");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
